[rtl/ffpa_pkg.sv]
`default_nettype none
package ffpa_pkg;

  localparam int PAGE_SLOTS = 64;
  localparam int PW = $clog2(PAGE_SLOTS);
  localparam int LW = $clog2(PAGE_SLOTS + 1);
  localparam int TW = 7;

  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_FREE     = 2'd1,
    KIND_ALLOC    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ADDR_PTR  = 2'd0,
    ADDR_S    = 2'd1,
    ADDR_TAIL = 2'd2
  } addr_sel_t;

  typedef enum logic [2:0] {
    WD_ALLOC = 3'd0,
    WD_SPLIT = 3'd1,
    WD_TAIL  = 3'd2,
    WD_ZERO  = 3'd3,
    WD_MERGE = 3'd4,
    WD_FREE  = 3'd5
  } wdata_sel_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_ZERO = 2'd1,
    PTR_ADV  = 2'd2,
    PTR_NXT  = 2'd3
  } ptr_op_t;

  typedef enum logic [1:0] {
    LENS_HOLD = 2'd0,
    LENS_LOAD = 2'd1,
    LENS_ADD  = 2'd2
  } lens_op_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_PTR  = 2'd1,
    IDX_TAIL = 2'd2
  } idx_op_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wd_sel;
    ptr_op_t    ptr_op;
    lens_op_t   lens_op;
    idx_op_t    idx_op;
    logic       emit;
    status_t    emit_st;
  } cmd_t;

  typedef struct packed {
    logic    is_free_act;
    logic    cnt0;
    logic    ptr_ge_pool;
    logic    s_ge_pool;
    logic    len0;
    logic    kind_free;
    logic    kind_alloc;
    logic    fits;
    logic    exact;
    logic    prev_hit;
    logic    ptr_ge_s;
    logic    out_busy;
  } sts_t;

endpackage
`default_nettype wire

[rtl/ffpa_if.sv]
`default_nettype none
interface ffpa_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] action;
  logic [6:0] page_count;
  logic [5:0] start_page;
  modport source (output valid, action, page_count, start_page, input ready);
  modport sink (input valid, action, page_count, start_page, output ready);
endinterface

interface ffpa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] page_index;
  modport source (output valid, status, page_index, input ready);
  modport sink (input valid, status, page_index, output ready);
endinterface

interface ffpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] total_pages;
  modport source (output valid, total_pages, input ready);
  modport sink (input valid, total_pages, output ready);
endinterface
`default_nettype wire

[rtl/ffpa_dp.sv]
`default_nettype none
module ffpa_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ffpa_pkg::cmd_t          cmd,
  output      ffpa_pkg::sts_t          sts,
  input  wire logic                    cfg_we,
  input  wire logic [ffpa_pkg::TW-1:0] cfg_val,
  input  wire logic [0:0]              in_action,
  input  wire logic [6:0]              in_count,
  input  wire logic [5:0]              in_start,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [1:0]              out_status,
  output      logic [5:0]              out_index
);

  localparam int PW = ffpa_pkg::PW;
  localparam int LW = ffpa_pkg::LW;
  localparam int EW = LW + 2;
  localparam int NP = ffpa_pkg::PAGE_SLOTS;

  logic [EW-1:0] mem [NP];
  logic [NP-1:0] vld_r;
  logic [EW-1:0] rd_q_r;
  logic          rd_vld_r;
  logic          rd_a0_r;

  logic [LW-1:0] pool_r;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [LW-1:0] cnt_r;
  logic [PW-1:0] s_r;
  logic [LW-1:0] lens_r;
  logic [PW-1:0] idx_r;
  logic          act_r;
  logic          out_valid_r;
  logic [1:0]    out_st_r;
  logic [PW-1:0] out_idx_r;

  logic [LW-1:0] rd_len;
  logic [1:0]    rd_kind;
  logic [LW-1:0] tail;
  logic [LW-1:0] s_ext;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic [LW-1:0] cfg_clamp;

  assign s_ext = {1'b0, s_r};

  always_comb begin
    if (rd_vld_r) begin
      rd_len  = rd_q_r[EW-1:2];
      rd_kind = rd_q_r[1:0];
    end else if (rd_a0_r) begin
      rd_len  = pool_r;
      rd_kind = ffpa_pkg::KIND_FREE;
    end else begin
      rd_len  = '0;
      rd_kind = ffpa_pkg::KIND_INTERIOR;
    end
  end

  assign tail = ptr_r + (rd_len - cnt_r);

  always_comb begin
    if (cfg_val == '0) begin
      cfg_clamp = LW'(1);
    end else if ({1'b0, cfg_val} > (ffpa_pkg::TW + 1)'(NP)) begin
      cfg_clamp = LW'(NP);
    end else begin
      cfg_clamp = cfg_val[LW-1:0];
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      ffpa_pkg::ADDR_S: rd_addr = s_r;
      default:          rd_addr = ptr_r[PW-1:0];
    endcase
    case (cmd.wr_sel)
      ffpa_pkg::ADDR_S:    wr_addr = s_r;
      ffpa_pkg::ADDR_TAIL: wr_addr = tail[PW-1:0];
      default:             wr_addr = ptr_r[PW-1:0];
    endcase
    case (cmd.wd_sel)
      ffpa_pkg::WD_ALLOC: wr_data = {rd_len, ffpa_pkg::KIND_ALLOC};
      ffpa_pkg::WD_SPLIT: wr_data = {rd_len - cnt_r, ffpa_pkg::KIND_FREE};
      ffpa_pkg::WD_TAIL:  wr_data = {cnt_r, ffpa_pkg::KIND_ALLOC};
      ffpa_pkg::WD_MERGE: wr_data = {rd_len + lens_r, ffpa_pkg::KIND_FREE};
      ffpa_pkg::WD_FREE:  wr_data = {lens_r, ffpa_pkg::KIND_FREE};
      default:            wr_data = {{LW{1'b0}}, ffpa_pkg::KIND_INTERIOR};
    endcase
    case (cmd.ptr_op)
      ffpa_pkg::PTR_ZERO: ptr_nxt = '0;
      ffpa_pkg::PTR_ADV:  ptr_nxt = ptr_r + rd_len;
      ffpa_pkg::PTR_NXT:  ptr_nxt = s_ext + rd_len;
      default:            ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      pool_r      <= LW'(NP);
      rd_vld_r    <= 1'b0;
      rd_a0_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        vld_r  <= '0;
        pool_r <= cfg_clamp;
      end else if (cmd.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        rd_a0_r  <= (rd_addr == '0);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      act_r <= in_action[0];
      cnt_r <= in_count[LW-1:0];
      s_r   <= in_start;
      idx_r <= '0;
    end else begin
      case (cmd.idx_op)
        ffpa_pkg::IDX_PTR:  idx_r <= ptr_r[PW-1:0];
        ffpa_pkg::IDX_TAIL: idx_r <= tail[PW-1:0];
        default:            idx_r <= idx_r;
      endcase
    end
    case (cmd.lens_op)
      ffpa_pkg::LENS_LOAD: lens_r <= rd_len;
      ffpa_pkg::LENS_ADD:  lens_r <= lens_r + rd_len;
      default:             lens_r <= lens_r;
    endcase
    if (cmd.emit) begin
      out_st_r  <= cmd.emit_st;
      out_idx_r <= (cmd.emit_st == ffpa_pkg::ST_OK) ? idx_r : '0;
    end
  end

  assign sts.is_free_act = act_r;
  assign sts.cnt0        = (cnt_r == '0);
  assign sts.ptr_ge_pool = (ptr_r >= pool_r);
  assign sts.s_ge_pool   = (s_ext >= pool_r);
  assign sts.len0        = (rd_len == '0);
  assign sts.kind_free   = (rd_kind == ffpa_pkg::KIND_FREE);
  assign sts.kind_alloc  = (rd_kind == ffpa_pkg::KIND_ALLOC);
  assign sts.fits        = (rd_len >= cnt_r);
  assign sts.exact       = (rd_len == cnt_r);
  assign sts.prev_hit    = ((ptr_r + rd_len) == s_ext);
  assign sts.ptr_ge_s    = (ptr_r >= s_ext);
  assign sts.out_busy    = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_st_r;
  assign out_index  = out_idx_r;

endmodule
`default_nettype wire

[rtl/ffpa_ctrl.sv]
`default_nettype none
module ffpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic [0:0]     in_action,
  input  wire logic [6:0]     in_count,
  input  wire ffpa_pkg::sts_t sts,
  output      ffpa_pkg::cmd_t cmd,
  output      logic           in_ready
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_A_RD  = 13'b0000000000010,
    S_A_EV  = 13'b0000000000100,
    S_A_TL  = 13'b0000000001000,
    S_F_CHK = 13'b0000000010000,
    S_F_EV  = 13'b0000000100000,
    S_F_NRD = 13'b0000001000000,
    S_F_NEV = 13'b0000010000000,
    S_F_SRD = 13'b0000100000000,
    S_F_SEV = 13'b0001000000000,
    S_F_WS  = 13'b0010000000000,
    S_F_WSI = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t            state_r, state_nxt;
  ffpa_pkg::status_t st_r, st_nxt;

  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    cmd         = '0;
    cmd.rd_sel  = ffpa_pkg::ADDR_PTR;
    cmd.wr_sel  = ffpa_pkg::ADDR_PTR;
    cmd.wd_sel  = ffpa_pkg::WD_ZERO;
    cmd.ptr_op  = ffpa_pkg::PTR_HOLD;
    cmd.lens_op = ffpa_pkg::LENS_HOLD;
    cmd.idx_op  = ffpa_pkg::IDX_HOLD;
    cmd.emit_st = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          cmd.ptr_op = ffpa_pkg::PTR_ZERO;
          if (in_action == ffpa_pkg::ACT_FREE) begin
            state_nxt = S_F_CHK;
          end else if (in_count == '0) begin
            st_nxt    = ffpa_pkg::ST_NO_FIT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        if (sts.ptr_ge_pool) begin
          st_nxt    = ffpa_pkg::ST_NO_FIT;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        if (sts.len0) begin
          st_nxt    = ffpa_pkg::ST_NO_FIT;
          state_nxt = S_DONE;
        end else if (sts.kind_free && sts.fits) begin
          cmd.wr_en = 1'b1;
          if (sts.exact) begin
            cmd.wd_sel = ffpa_pkg::WD_ALLOC;
            cmd.idx_op = ffpa_pkg::IDX_PTR;
            st_nxt     = ffpa_pkg::ST_OK;
            state_nxt  = S_DONE;
          end else begin
            cmd.wd_sel = ffpa_pkg::WD_SPLIT;
            state_nxt  = S_A_TL;
          end
        end else begin
          cmd.ptr_op = ffpa_pkg::PTR_ADV;
          state_nxt  = S_A_RD;
        end
      end
      S_A_TL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffpa_pkg::ADDR_TAIL;
        cmd.wd_sel = ffpa_pkg::WD_TAIL;
        cmd.idx_op = ffpa_pkg::IDX_TAIL;
        st_nxt     = ffpa_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_F_CHK: begin
        if (sts.s_ge_pool) begin
          st_nxt    = ffpa_pkg::ST_BAD_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffpa_pkg::ADDR_S;
          state_nxt  = S_F_EV;
        end
      end
      S_F_EV: begin
        if (!sts.kind_alloc) begin
          st_nxt    = ffpa_pkg::ST_BAD_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.lens_op = ffpa_pkg::LENS_LOAD;
          cmd.ptr_op  = ffpa_pkg::PTR_NXT;
          state_nxt   = S_F_NRD;
        end
      end
      S_F_NRD: begin
        if (sts.ptr_ge_pool) begin
          cmd.ptr_op = ffpa_pkg::PTR_ZERO;
          state_nxt  = S_F_SRD;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_F_NEV;
        end
      end
      S_F_NEV: begin
        if (sts.kind_free) begin
          cmd.lens_op = ffpa_pkg::LENS_ADD;
          cmd.wr_en   = 1'b1;
          cmd.wd_sel  = ffpa_pkg::WD_ZERO;
        end
        cmd.ptr_op = ffpa_pkg::PTR_ZERO;
        state_nxt  = S_F_SRD;
      end
      S_F_SRD: begin
        if (sts.ptr_ge_s) begin
          state_nxt = S_F_WS;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_F_SEV;
        end
      end
      S_F_SEV: begin
        if (sts.len0) begin
          state_nxt = S_F_WS;
        end else if (sts.prev_hit) begin
          if (sts.kind_free) begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = ffpa_pkg::WD_MERGE;
            state_nxt  = S_F_WSI;
          end else begin
            state_nxt = S_F_WS;
          end
        end else begin
          cmd.ptr_op = ffpa_pkg::PTR_ADV;
          state_nxt  = S_F_SRD;
        end
      end
      S_F_WS: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffpa_pkg::ADDR_S;
        cmd.wd_sel = ffpa_pkg::WD_FREE;
        st_nxt     = ffpa_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_F_WSI: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffpa_pkg::ADDR_S;
        cmd.wd_sel = ffpa_pkg::WD_ZERO;
        st_nxt     = ffpa_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ffpa_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
`default_nettype wire

[rtl/first_fit_page_allocator_top.sv]
`default_nettype none
// channel  dir  beat payload
// in_ch    in   action, page_count, start_page
// out_ch   out  status, page_index
// cfg_ch   in   total_pages (any write rebuilds the pool as one free run)
//
// Each beat is one walk of the run table in a single-port 64-entry memory;
// every run visited takes an address state and a registered read-data state;
// an allocate walks runs from page 0, a free walks the runs before its start page.
// Reset and config writes clear all the per-page valid bits together.
// A finished result sits in the output register; the walk stalls only in its
// last state while the previous result is still not taken.
module first_fit_page_allocator_top (
  input wire logic   clk,
  input wire logic   rst_n,
  ffpa_in_if.sink    in_ch,
  ffpa_out_if.source out_ch,
  ffpa_cfg_if.sink   cfg_ch
);

  ffpa_pkg::cmd_t cmd;
  ffpa_pkg::sts_t sts;
  logic           in_fire;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_ch.action),
    .in_count  (in_ch.page_count),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready)
  );

  ffpa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_ch.valid),
    .cfg_val    (cfg_ch.total_pages),
    .in_action  (in_ch.action),
    .in_count   (in_ch.page_count),
    .in_start   (in_ch.start_page),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_index  (out_ch.page_index)
  );

endmodule
`default_nettype wire

[rtl/ffpa_chk.sv]
`default_nettype none
module ffpa_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [5:0] out_index
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ffpa_pkg::ST_BAD_FREE)
    else $error("undefined status code");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffpa_pkg::ST_OK |-> out_index == '0)
    else $error("page index set on failed result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_index))
    else $error("stalled result changed");

endmodule

bind first_fit_page_allocator_top ffpa_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_index  (out_ch.page_index)
);
`default_nettype wire
